// ===== sv/oic_pkg.sv =====
package oic_pkg;

    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int DIM_W   = 7;
    localparam int COUNT_W = 12;
    localparam int SIZE_W  = 13;
    localparam int LIN_W   = 13;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    // register indexes (paddr[2])
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
    } grid_cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LAND_RD,
        ST_LAND_CHK,
        ST_NB,
        ST_NB_CHK,
        ST_FIND_RD,
        ST_FIND_WT,
        ST_CMP_RD,
        ST_CMP_WR,
        ST_SZ_B,
        ST_SZ_DONE,
        ST_DONE
    } state_t;

endpackage

// ===== sv/oic_if.sv =====
interface oic_in_if
    import oic_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;

    modport source (output valid, output cell_row, output cell_col, input ready);
    modport sink   (input valid, input cell_row, input cell_col, output ready);
endinterface

interface oic_out_if
    import oic_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] island_count;
    logic               bad_cell;

    modport source (output valid, output island_count, output bad_cell, input ready);
    modport sink   (input valid, input island_count, input bad_cell, output ready);
endinterface

// ===== sv/oic_ram.sv =====
module oic_ram #(
    parameter int WIDTH  = 1,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/oic_apb_regs.sv =====
module oic_apb_regs
    import oic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output grid_cfg_t   cfg
);

    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    logic             wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DIM_RESET;
            cols_reg <= DIM_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_ROWS: rows_reg <= pwdata[DIM_W-1:0];
                REG_COLS: cols_reg <= pwdata[DIM_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ROWS: prdata = {25'd0, rows_reg};
            REG_COLS: prdata = {25'd0, cols_reg};
            default:  prdata = 32'd0;
        endcase
    end

    assign cfg.rows = rows_reg;
    assign cfg.cols = cols_reg;

endmodule

// ===== sv/online_grid_island_counter.sv =====
// Online island counter. Each input transaction names a grid cell that turns
// into land; one result transaction returns the number of separate land
// components (4-connected) and a bad_cell flag for cells outside the grid set
// by the grid_rows/grid_cols registers (APB, byte addresses 0 and 4, values
// above MAX_ROWS/MAX_COLS saturate). Components are kept in a union-find
// structure (union by size, full path compression) in three simple dual-port
// RAMs: land map, parent links and set sizes. After reset the land map is
// swept clear, one entry per cycle, and no cell is accepted until the sweep
// is done. An outside cell goes straight to its result; any other cell is
// looked up in the land map, and an already-land cell changes nothing. A new
// cell becomes a singleton set, then its four neighbors are checked in turn:
// off-grid ones are skipped, and for each land neighbor both roots are found
// (walking the parent links, then compressing the walked links) and the two
// sets are merged when they differ. Every item also waits while the previous
// result is still unaccepted. The block takes one cell at a time; a finished
// result waits in the output register while the next cell is accepted.
module online_grid_island_counter
    import oic_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    oic_in_if.sink      cell_in,
    oic_out_if.source   result_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [DIM_W-1:0] MAX_R = (MAX_ROWS > 127) ? 7'd127 : 7'(MAX_ROWS);
    localparam logic [DIM_W-1:0] MAX_C = (MAX_COLS > 127) ? 7'd127 : 7'(MAX_COLS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);

    grid_cfg_t cfg;

    oic_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // effective grid shape, saturated to storage
    logic [DIM_W-1:0] rows_eff;
    logic [DIM_W-1:0] cols_eff;
    assign rows_eff = (cfg.rows > MAX_R) ? MAX_R : cfg.rows;
    assign cols_eff = (cfg.cols > MAX_C) ? MAX_C : cfg.cols;

    // memories
    logic             land_we, land_wdata, land_rdata;
    logic [IDX_W-1:0] land_waddr, land_raddr;
    logic             par_we;
    logic [IDX_W-1:0] par_waddr, par_wdata, par_raddr, par_rdata;
    logic             size_we;
    logic [IDX_W-1:0] size_waddr, size_raddr;
    logic [SIZE_W-1:0] size_wdata, size_rdata;

    oic_ram #(.WIDTH(1), .DEPTH(CELLS), .ADDR_W(IDX_W)) u_land (
        .clk(clk), .we(land_we), .waddr(land_waddr), .wdata(land_wdata),
        .raddr(land_raddr), .rdata(land_rdata)
    );

    oic_ram #(.WIDTH(IDX_W), .DEPTH(CELLS), .ADDR_W(IDX_W)) u_parent (
        .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
        .raddr(par_raddr), .rdata(par_rdata)
    );

    oic_ram #(.WIDTH(SIZE_W), .DEPTH(CELLS), .ADDR_W(IDX_W)) u_size (
        .clk(clk), .we(size_we), .waddr(size_waddr), .wdata(size_wdata),
        .raddr(size_raddr), .rdata(size_rdata)
    );

    // sequencer state
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [DIM_W-1:0]   rows_reg, rows_next;
    logic [DIM_W-1:0]   cols_reg, cols_next;
    logic [LIN_W-1:0]   here_reg, here_next;
    logic [IDX_W-1:0]   there_reg, there_next;
    logic [1:0]         k_reg, k_next;
    logic [IDX_W-1:0]   x_reg, x_next;
    logic [IDX_W-1:0]   root_reg, root_next;
    logic [IDX_W-1:0]   ra_reg, ra_next;
    logic               fsel_reg, fsel_next;
    logic [SIZE_W-1:0]  sa_reg, sa_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               bad_reg, bad_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_bad_reg, out_bad_next;

    logic             in_bad;
    logic [LIN_W-1:0] in_lin;
    logic             nb_ok;
    logic [LIN_W-1:0] nb_lin;
    logic [IDX_W-1:0] here_idx;
    logic [SIZE_W-1:0] size_sum;

    assign in_bad = ({1'b0, cell_in.cell_row} >= rows_eff) ||
                    ({1'b0, cell_in.cell_col} >= cols_eff);
    assign in_lin = LIN_W'(cell_in.cell_row) * LIN_W'(cols_eff) + LIN_W'(cell_in.cell_col);
    assign here_idx = IDX_W'(here_reg);
    assign size_sum = sa_reg + size_rdata;

    // neighbor k: up, down, left, right
    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                nb_ok  = (row_reg != '0);
                nb_lin = here_reg - LIN_W'(cols_reg);
            end
            2'd1:
            begin
                nb_ok  = ({1'b0, row_reg} + 7'd1) < rows_reg;
                nb_lin = here_reg + LIN_W'(cols_reg);
            end
            2'd2:
            begin
                nb_ok  = (col_reg != '0);
                nb_lin = here_reg - LIN_W'(1);
            end
            default:
            begin
                nb_ok  = ({1'b0, col_reg} + 7'd1) < cols_reg;
                nb_lin = here_reg + LIN_W'(1);
            end
        endcase
    end

    assign cell_in.ready         = (state_reg == ST_IDLE);
    assign result_out.valid        = out_valid_reg;
    assign result_out.island_count = out_count_reg;
    assign result_out.bad_cell     = out_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        col_reg       <= col_next;
        rows_reg      <= rows_next;
        cols_reg      <= cols_next;
        here_reg      <= here_next;
        there_reg     <= there_next;
        k_reg         <= k_next;
        x_reg         <= x_next;
        root_reg      <= root_next;
        ra_reg        <= ra_next;
        fsel_reg      <= fsel_next;
        sa_reg        <= sa_next;
        bad_reg       <= bad_next;
        out_count_reg <= out_count_next;
        out_bad_reg   <= out_bad_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        here_next      = here_reg;
        there_next     = there_reg;
        k_next         = k_reg;
        x_next         = x_reg;
        root_next      = root_reg;
        ra_next        = ra_reg;
        fsel_next      = fsel_reg;
        sa_next        = sa_reg;
        count_next     = count_reg;
        bad_next       = bad_reg;
        out_count_next = out_count_reg;
        out_bad_next   = out_bad_reg;
        out_valid_next = out_valid_reg && !result_out.ready;

        land_we    = 1'b0;
        land_waddr = here_idx;
        land_wdata = 1'b1;
        land_raddr = here_idx;
        par_we     = 1'b0;
        par_waddr  = here_idx;
        par_wdata  = here_idx;
        par_raddr  = x_reg;
        size_we    = 1'b0;
        size_waddr = here_idx;
        size_wdata = SIZE_W'(1);
        size_raddr = ra_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                land_we    = 1'b1;
                land_waddr = clr_reg;
                land_wdata = 1'b0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cell_in.valid)
                begin
                    row_next  = cell_in.cell_row;
                    col_next  = cell_in.cell_col;
                    rows_next = rows_eff;
                    cols_next = cols_eff;
                    here_next = in_lin;
                    bad_next  = in_bad;
                    state_next = in_bad ? ST_DONE : ST_LAND_RD;
                end
            end

            ST_LAND_RD:
            begin
                state_next = ST_LAND_CHK;
            end

            ST_LAND_CHK:
            begin
                if (land_rdata)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    // new land: make it a singleton set
                    land_we    = 1'b1;
                    par_we     = 1'b1;
                    size_we    = 1'b1;
                    count_next = count_reg + 1'b1;
                    k_next     = 2'd0;
                    state_next = ST_NB;
                end
            end

            ST_NB:
            begin
                if (nb_ok)
                begin
                    land_raddr = IDX_W'(nb_lin);
                    there_next = IDX_W'(nb_lin);
                    state_next = ST_NB_CHK;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = (k_reg == 2'd3) ? ST_DONE : ST_NB;
                end
            end

            ST_NB_CHK:
            begin
                if (land_rdata)
                begin
                    fsel_next  = 1'b0;
                    x_next     = here_idx;
                    state_next = ST_FIND_RD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = (k_reg == 2'd3) ? ST_DONE : ST_NB;
                end
            end

            ST_FIND_RD:
            begin
                state_next = ST_FIND_WT;
            end

            ST_FIND_WT:
            begin
                if (par_rdata == x_reg)
                begin
                    // root found; restart from the start for compression
                    root_next  = x_reg;
                    x_next     = fsel_reg ? there_reg : here_idx;
                    state_next = ST_CMP_RD;
                end
                else
                begin
                    par_raddr = par_rdata;
                    x_next    = par_rdata;
                end
            end

            ST_CMP_RD:
            begin
                if (x_reg == root_reg)
                begin
                    if (!fsel_reg)
                    begin
                        ra_next    = root_reg;
                        fsel_next  = 1'b1;
                        x_next     = there_reg;
                        state_next = ST_FIND_RD;
                    end
                    else if (ra_reg == root_reg)
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = (k_reg == 2'd3) ? ST_DONE : ST_NB;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        size_raddr = ra_reg;
                        state_next = ST_SZ_B;
                    end
                end
                else
                begin
                    state_next = ST_CMP_WR;
                end
            end

            ST_CMP_WR:
            begin
                par_we     = 1'b1;
                par_waddr  = x_reg;
                par_wdata  = root_reg;
                x_next     = par_rdata;
                state_next = ST_CMP_RD;
            end

            ST_SZ_B:
            begin
                sa_next    = size_rdata;
                size_raddr = root_reg;
                state_next = ST_SZ_DONE;
            end

            ST_SZ_DONE:
            begin
                // union by size; ties keep the new cell's root
                par_we     = 1'b1;
                size_we    = 1'b1;
                size_wdata = size_sum;
                if (sa_reg < size_rdata)
                begin
                    par_waddr  = ra_reg;
                    par_wdata  = root_reg;
                    size_waddr = root_reg;
                end
                else
                begin
                    par_waddr  = root_reg;
                    par_wdata  = ra_reg;
                    size_waddr = ra_reg;
                end
                k_next     = k_reg + 1'b1;
                state_next = (k_reg == 2'd3) ? ST_DONE : ST_NB;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    out_bad_next   = bad_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
